>>> hw/rtl/cdlu_pkg.sv
// shared types, constants and codes of the content directory
`timescale 1ns / 1ps
package cdlu_pkg;

  localparam int MAX_PEERS_DEF = 8;
  localparam int SLOTS_DEF     = 4;

  localparam int KEY_HI_W = 16;
  localparam int KEY_LO_W = 64;
  localparam int KEY_W    = KEY_HI_W + KEY_LO_W;
  localparam int LOC_W    = 64;
  localparam int CNT_W    = 16;
  localparam int ENTRY_W  = KEY_W + LOC_W + CNT_W;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [2:0] {
    ACT_REG       = 3'd0,
    ACT_SEARCH    = 3'd1,
    ACT_DEREG     = 3'd2,
    ACT_DEREG_ALL = 3'd3,
    ACT_LIST      = 3'd4
  } action_t;

  typedef enum logic [3:0] {
    ST_ACK    = 4'd0,
    ST_FOUND  = 4'd1,
    ST_ITEM   = 4'd2,
    ST_END    = 4'd3,
    ST_NOPEER = 4'd4,
    ST_PFULL  = 4'd5,
    ST_DUP    = 4'd6,
    ST_SFULL  = 4'd7,
    ST_NOCONT = 4'd8
  } status_t;

  typedef enum logic [1:0] {
    EK_PLAIN,
    EK_FOUND,
    EK_ITEM
  } emit_kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_PEER_SCAN,
    S_SLOT_RD,
    S_SLOT_CMP,
    S_NEW_PEER,
    S_ADD,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_SRCH_SCAN,
    S_SRCH_DONE,
    S_SRCH_EMIT,
    S_LIST_RD,
    S_LIST_EMIT,
    S_WAIT_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic       cap;
    logic       clr_q;
    logic       clr_t;
    logic       inc_q;
    logic       inc_t;
    logic       clr_best;
    logic       srch_step;
    logic       q_from_best;
    logic       rd_slot;
    logic       rd_shift;
    logic       wr_shift;
    logic       new_peer;
    logic       add_entry;
    logic       clr_slots;
    logic       dec_slots;
    logic       bump;
    logic       emit;
    emit_kind_t emit_kind;
    status_t    emit_code;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    action_t action;
    logic    peer_end;
    logic    peer_hit;
    logic    peers_full;
    logic    slot_end;
    logic    slots_full;
    logic    slot_hit;
    logic    shift_more;
    logic    pipe_v;
    logic    best_hit;
    logic    out_free;
  } stat_t;

endpackage

>>> hw/rtl/cdlu_if.sv
// request and response channel interfaces
`timescale 1ns / 1ps
interface cdlu_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [15:0] peer_key_hi;
  logic [63:0] peer_key_lo;
  logic [15:0] item_key_hi;
  logic [63:0] item_key_lo;
  logic [63:0] locator_in;
  modport source (output valid, action, peer_key_hi, peer_key_lo, item_key_hi,
                  item_key_lo, locator_in, input ready);
  modport sink (input valid, action, peer_key_hi, peer_key_lo, item_key_hi,
                item_key_lo, locator_in, output ready);
endinterface

interface cdlu_rsp_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [15:0] peer_out_hi;
  logic [63:0] peer_out_lo;
  logic [15:0] item_out_hi;
  logic [63:0] item_out_lo;
  logic [63:0] locator_out;
  logic        last;
  modport source (output valid, status, peer_out_hi, peer_out_lo, item_out_hi,
                  item_out_lo, locator_out, last, input ready);
  modport sink (input valid, status, peer_out_hi, peer_out_lo, item_out_hi,
                item_out_lo, locator_out, last, output ready);
endinterface

>>> hw/rtl/content_directory_least_used.sv
// top level of the content directory with least-used search
`timescale 1ns / 1ps
// Directory of up to MAX_PEERS peers with SLOTS content entries each, one request
// beat at a time. Register, deregister and deregister-all walk the peer table one
// peer per cycle; register and deregister then read and compare the peer's slots in
// S_SLOT_RD and S_SLOT_CMP, and a deregister shifts later entries down through
// S_SHIFT_RD and S_SHIFT_WR. Search streams every stored entry through the entry
// ram at one per cycle. List reads each entry in S_LIST_RD and emits it from
// S_LIST_EMIT, where it waits while the response side stalls. The entry ram has one
// read and one write port. A new request is taken only when the previous one has
// issued its last response beat; that beat may still sit in the output register.
module content_directory_least_used #(
  parameter int MAX_PEERS = cdlu_pkg::MAX_PEERS_DEF,
  parameter int SLOTS     = cdlu_pkg::SLOTS_DEF
) (
  input logic        clk,
  input logic        rst,
  cdlu_req_if.sink   req,
  cdlu_rsp_if.source rsp
);
  cdlu_pkg::cmd_t  cmd;
  cdlu_pkg::stat_t st;

  cdlu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .st        (st),
    .cmd       (cmd)
  );

  cdlu_datapath #(.MAX_PEERS(MAX_PEERS), .SLOTS(SLOTS)) u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cmd (cmd),
    .st  (st)
  );
endmodule

>>> hw/rtl/cdlu_ram.sv
// generic single write, single read ram with registered read
`timescale 1ns / 1ps
module cdlu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

>>> hw/rtl/cdlu_datapath.sv
// directory datapath: peer table, slot counts, entry ram, search best and result register
`timescale 1ns / 1ps
module cdlu_datapath #(
  parameter int MAX_PEERS = cdlu_pkg::MAX_PEERS_DEF,
  parameter int SLOTS     = cdlu_pkg::SLOTS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  cdlu_req_if.sink        req,
  cdlu_rsp_if.source      rsp,
  input  cdlu_pkg::cmd_t  cmd,
  output cdlu_pkg::stat_t st
);
  localparam int ENTRIES = MAX_PEERS * SLOTS;
  localparam int PW  = $clog2(MAX_PEERS + 1);
  localparam int PIW = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
  localparam int SW  = $clog2(SLOTS + 1);
  localparam int AW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int KW  = cdlu_pkg::KEY_W;
  localparam int LW  = cdlu_pkg::LOC_W;
  localparam int CW  = cdlu_pkg::CNT_W;
  localparam int EW  = cdlu_pkg::ENTRY_W;
  localparam int HW  = cdlu_pkg::KEY_HI_W;
  localparam int LOW = cdlu_pkg::KEY_LO_W;

  // latched request
  logic [2:0]    req_action;
  logic [KW-1:0] req_peer;
  logic [KW-1:0] req_item;
  logic [LW-1:0] req_loc;

  // directory state
  logic [PW-1:0]  peers_used;
  logic [SW-1:0]  slots_used [MAX_PEERS];
  logic [KW-1:0]  peer_key [MAX_PEERS];

  // scan pointers
  logic [PW-1:0] q;
  logic [SW-1:0] t;

  // search pipe and best entry
  logic           pipe_v;
  logic [AW-1:0]  pipe_addr;
  logic [PW-1:0]  pipe_q;
  logic           best_hit;
  logic [EW-1:0]  best_entry;
  logic [AW-1:0]  best_addr;
  logic [PW-1:0]  best_q;

  // ram ports
  logic          we;
  logic [AW-1:0] waddr;
  logic [EW-1:0] wdata;
  logic          re;
  logic [AW-1:0] raddr;
  logic [EW-1:0] rdata;

  // result register
  logic          out_v;
  logic [3:0]    out_status;
  logic [KW-1:0] out_peer;
  logic [KW-1:0] out_item;
  logic [LW-1:0] out_loc;
  logic          out_last;

  logic [PIW-1:0] qi;
  logic [SW-1:0]  q_slots;
  logic [AW-1:0]  addr_qt;
  logic [AW-1:0]  addr_qt1;
  logic [SW:0]    t_inc;
  logic [KW-1:0]  rd_key;
  logic [CW-1:0]  rd_cnt;
  logic [CW-1:0]  best_cnt;
  logic           srch_take;
  logic [CW-1:0]  bump_cnt;

  assign qi       = q[PIW-1:0];
  assign q_slots  = slots_used[qi];
  assign addr_qt  = AW'(int'(q) * SLOTS + int'(t));
  assign addr_qt1 = AW'(int'(q) * SLOTS + int'(t) + 1);
  assign t_inc    = {1'b0, t} + (SW+1)'(1);
  assign rd_key   = rdata[EW-1 -: KW];
  assign rd_cnt   = rdata[CW-1:0];
  assign best_cnt = best_entry[CW-1:0];
  assign srch_take = pipe_v && (rd_key == req_item) && (!best_hit || rd_cnt < best_cnt);
  assign bump_cnt = (best_cnt == cdlu_pkg::CNT_MAX) ? best_cnt : best_cnt + CW'(1);

  // status to controller
  always_comb begin
    st.action     = cdlu_pkg::action_t'(req_action);
    st.peer_end   = q >= peers_used;
    st.peer_hit   = peer_key[qi] == req_peer;
    st.peers_full = peers_used >= PW'(MAX_PEERS);
    st.slot_end   = t >= q_slots;
    st.slots_full = q_slots >= SW'(SLOTS);
    st.slot_hit   = rd_key == req_item;
    st.shift_more = t_inc < {1'b0, q_slots};
    st.pipe_v     = pipe_v;
    st.best_hit   = best_hit;
    st.out_free   = !out_v || rsp.ready;
  end

  // ram read port select
  always_comb begin
    re    = 1'b0;
    raddr = addr_qt;
    if (cmd.rd_slot) begin
      re = 1'b1;
    end else if (cmd.rd_shift) begin
      re    = 1'b1;
      raddr = addr_qt1;
    end else if (cmd.srch_step && !st.peer_end && !st.slot_end) begin
      re = 1'b1;
    end
  end

  // ram write port select
  always_comb begin
    we    = 1'b0;
    waddr = addr_qt;
    wdata = {req_item, req_loc, CW'(0)};
    if (cmd.new_peer) begin
      we    = 1'b1;
      waddr = AW'(int'(peers_used) * SLOTS);
    end else if (cmd.add_entry) begin
      we    = 1'b1;
      waddr = AW'(int'(q) * SLOTS + int'(q_slots));
    end else if (cmd.wr_shift) begin
      we    = 1'b1;
      wdata = rdata;
    end else if (cmd.bump) begin
      we    = 1'b1;
      waddr = best_addr;
      wdata = {best_entry[EW-1:CW], bump_cnt};
    end
  end

  cdlu_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // request capture and peer key table
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      req_action <= req.action;
      req_peer   <= {req.peer_key_hi, req.peer_key_lo};
      req_item   <= {req.item_key_hi, req.item_key_lo};
      req_loc    <= req.locator_in;
    end
    if (cmd.new_peer) begin
      peer_key[peers_used[PIW-1:0]] <= req_peer;
    end
  end

  // peer and slot counts
  always_ff @(posedge clk) begin
    if (rst) begin
      peers_used <= '0;
      for (int i = 0; i < MAX_PEERS; i++) begin
        slots_used[i] <= '0;
      end
    end else begin
      if (cmd.new_peer) begin
        slots_used[peers_used[PIW-1:0]] <= SW'(1);
        peers_used <= peers_used + PW'(1);
      end
      if (cmd.add_entry) begin
        slots_used[qi] <= q_slots + SW'(1);
      end
      if (cmd.clr_slots) begin
        slots_used[qi] <= '0;
      end
      if (cmd.dec_slots) begin
        slots_used[qi] <= q_slots - SW'(1);
      end
    end
  end

  // scan pointers
  always_ff @(posedge clk) begin
    if (cmd.clr_q) begin
      q <= '0;
    end else if (cmd.q_from_best) begin
      q <= best_q;
    end else if (cmd.inc_q) begin
      q <= q + PW'(1);
    end else if (cmd.srch_step && !st.peer_end) begin
      if (st.slot_end || !st.shift_more) begin
        q <= q + PW'(1);
      end
    end
    if (cmd.clr_t || cmd.inc_q) begin
      t <= '0;
    end else if (cmd.inc_t) begin
      t <= t + SW'(1);
    end else if (cmd.srch_step && !st.peer_end) begin
      if (st.slot_end || !st.shift_more) begin
        t <= '0;
      end else begin
        t <= t + SW'(1);
      end
    end
  end

  // search pipe and least-used tracking
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_best) begin
      pipe_v   <= 1'b0;
      best_hit <= 1'b0;
    end else if (cmd.srch_step) begin
      pipe_v <= !st.peer_end && !st.slot_end;
      if (srch_take) begin
        best_hit <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.srch_step) begin
      pipe_addr <= addr_qt;
      pipe_q    <= q;
      if (srch_take) begin
        best_entry <= rdata;
        best_addr  <= pipe_addr;
        best_q     <= pipe_q;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (cmd.emit) begin
      out_v <= 1'b1;
    end else if (rsp.ready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status <= cmd.emit_code;
      out_last   <= cmd.emit_kind != cdlu_pkg::EK_ITEM;
      case (cmd.emit_kind)
        cdlu_pkg::EK_FOUND: begin
          out_peer <= peer_key[qi];
          out_item <= best_entry[EW-1 -: KW];
          out_loc  <= best_entry[CW +: LW];
        end
        cdlu_pkg::EK_ITEM: begin
          out_peer <= '0;
          out_item <= rd_key;
          out_loc  <= '0;
        end
        default: begin
          out_peer <= '0;
          out_item <= '0;
          out_loc  <= '0;
        end
      endcase
    end
  end

  assign rsp.valid       = out_v;
  assign rsp.status      = out_status;
  assign rsp.peer_out_hi = out_peer[KW-1 -: HW];
  assign rsp.peer_out_lo = out_peer[LOW-1:0];
  assign rsp.item_out_hi = out_item[KW-1 -: HW];
  assign rsp.item_out_lo = out_item[LOW-1:0];
  assign rsp.locator_out = out_loc;
  assign rsp.last        = out_last;
endmodule

>>> hw/rtl/cdlu_ctrl.sv
// directory controller state machine
`timescale 1ns / 1ps
module cdlu_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  cdlu_pkg::stat_t st,
  output cdlu_pkg::cmd_t  cmd
);
  cdlu_pkg::state_t  state, state_next;
  cdlu_pkg::status_t res_code, res_code_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= cdlu_pkg::S_IDLE;
      res_code <= cdlu_pkg::ST_ACK;
    end else begin
      state    <= state_next;
      res_code <= res_code_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next    = state;
    res_code_next = res_code;
    req_ready     = 1'b0;
    cmd           = '0;
    cmd.emit_kind = cdlu_pkg::EK_PLAIN;
    cmd.emit_code = res_code;
    case (state)
      cdlu_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.cap      = 1'b1;
          cmd.clr_q    = 1'b1;
          cmd.clr_t    = 1'b1;
          cmd.clr_best = 1'b1;
          state_next   = cdlu_pkg::S_DISPATCH;
        end
      end
      cdlu_pkg::S_DISPATCH: begin
        case (st.action)
          cdlu_pkg::ACT_REG, cdlu_pkg::ACT_DEREG, cdlu_pkg::ACT_DEREG_ALL:
            state_next = cdlu_pkg::S_PEER_SCAN;
          cdlu_pkg::ACT_SEARCH: state_next = cdlu_pkg::S_SRCH_SCAN;
          cdlu_pkg::ACT_LIST:   state_next = cdlu_pkg::S_LIST_RD;
          default:              state_next = cdlu_pkg::S_IDLE;
        endcase
      end
      // linear search of the peer table
      cdlu_pkg::S_PEER_SCAN: begin
        if (st.peer_end) begin
          state_next = cdlu_pkg::S_WAIT_EMIT;
          if (st.action != cdlu_pkg::ACT_REG) begin
            res_code_next = cdlu_pkg::ST_NOPEER;
          end else if (st.peers_full) begin
            res_code_next = cdlu_pkg::ST_PFULL;
          end else begin
            state_next = cdlu_pkg::S_NEW_PEER;
          end
        end else if (st.peer_hit) begin
          if (st.action == cdlu_pkg::ACT_DEREG_ALL) begin
            cmd.clr_slots = 1'b1;
            res_code_next = cdlu_pkg::ST_ACK;
            state_next    = cdlu_pkg::S_WAIT_EMIT;
          end else begin
            cmd.clr_t  = 1'b1;
            state_next = cdlu_pkg::S_SLOT_RD;
          end
        end else begin
          cmd.inc_q = 1'b1;
        end
      end
      // content search within the found peer
      cdlu_pkg::S_SLOT_RD: begin
        if (st.slot_end) begin
          state_next = cdlu_pkg::S_WAIT_EMIT;
          if (st.action != cdlu_pkg::ACT_REG) begin
            res_code_next = cdlu_pkg::ST_NOCONT;
          end else if (st.slots_full) begin
            res_code_next = cdlu_pkg::ST_SFULL;
          end else begin
            state_next = cdlu_pkg::S_ADD;
          end
        end else begin
          cmd.rd_slot = 1'b1;
          state_next  = cdlu_pkg::S_SLOT_CMP;
        end
      end
      cdlu_pkg::S_SLOT_CMP: begin
        if (st.slot_hit) begin
          if (st.action == cdlu_pkg::ACT_REG) begin
            res_code_next = cdlu_pkg::ST_DUP;
            state_next    = cdlu_pkg::S_WAIT_EMIT;
          end else begin
            state_next = cdlu_pkg::S_SHIFT_RD;
          end
        end else begin
          cmd.inc_t  = 1'b1;
          state_next = cdlu_pkg::S_SLOT_RD;
        end
      end
      cdlu_pkg::S_NEW_PEER: begin
        cmd.new_peer  = 1'b1;
        res_code_next = cdlu_pkg::ST_ACK;
        state_next    = cdlu_pkg::S_WAIT_EMIT;
      end
      cdlu_pkg::S_ADD: begin
        cmd.add_entry = 1'b1;
        res_code_next = cdlu_pkg::ST_ACK;
        state_next    = cdlu_pkg::S_WAIT_EMIT;
      end
      // close the gap left by a removed entry
      cdlu_pkg::S_SHIFT_RD: begin
        if (st.shift_more) begin
          cmd.rd_shift = 1'b1;
          state_next   = cdlu_pkg::S_SHIFT_WR;
        end else begin
          cmd.dec_slots = 1'b1;
          res_code_next = cdlu_pkg::ST_ACK;
          state_next    = cdlu_pkg::S_WAIT_EMIT;
        end
      end
      cdlu_pkg::S_SHIFT_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.inc_t    = 1'b1;
        state_next   = cdlu_pkg::S_SHIFT_RD;
      end
      // pipelined scan for the least-used match
      cdlu_pkg::S_SRCH_SCAN: begin
        cmd.srch_step = 1'b1;
        if (st.peer_end && !st.pipe_v) begin
          state_next = cdlu_pkg::S_SRCH_DONE;
        end
      end
      cdlu_pkg::S_SRCH_DONE: begin
        if (st.best_hit) begin
          cmd.q_from_best = 1'b1;
          state_next      = cdlu_pkg::S_SRCH_EMIT;
        end else begin
          res_code_next = cdlu_pkg::ST_NOCONT;
          state_next    = cdlu_pkg::S_WAIT_EMIT;
        end
      end
      cdlu_pkg::S_SRCH_EMIT: begin
        if (st.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = cdlu_pkg::EK_FOUND;
          cmd.emit_code = cdlu_pkg::ST_FOUND;
          cmd.bump      = 1'b1;
          state_next    = cdlu_pkg::S_IDLE;
        end
      end
      // list walk, one beat per entry
      cdlu_pkg::S_LIST_RD: begin
        if (st.peer_end) begin
          res_code_next = cdlu_pkg::ST_END;
          state_next    = cdlu_pkg::S_WAIT_EMIT;
        end else if (st.slot_end) begin
          cmd.inc_q = 1'b1;
        end else begin
          cmd.rd_slot = 1'b1;
          state_next  = cdlu_pkg::S_LIST_EMIT;
        end
      end
      cdlu_pkg::S_LIST_EMIT: begin
        if (st.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = cdlu_pkg::EK_ITEM;
          cmd.emit_code = cdlu_pkg::ST_ITEM;
          cmd.inc_t     = 1'b1;
          state_next    = cdlu_pkg::S_LIST_RD;
        end
      end
      cdlu_pkg::S_WAIT_EMIT: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          state_next = cdlu_pkg::S_IDLE;
        end
      end
      default: state_next = cdlu_pkg::S_IDLE;
    endcase
  end
endmodule

>>> tb/content_directory_least_used_tb.sv
// testbench of the content directory with least-used search
`timescale 1ns / 1ps
module content_directory_least_used_tb;

  localparam int NPEER = cdlu_pkg::MAX_PEERS_DEF;
  localparam int NSLOT = cdlu_pkg::SLOTS_DEF;
  localparam int NENT = NPEER * NSLOT;
  localparam int STALL_LIMIT = 5000;
  localparam int PRESSURE_CYCLES = 400;

  typedef struct packed {
    logic [2:0]  act;
    logic [79:0] pkey;
    logic [79:0] ikey;
    logic [63:0] loc;
  } dir_req_t;

  typedef struct packed {
    cdlu_pkg::status_t st;
    logic [79:0]       pkey;
    logic [79:0]       ikey;
    logic [63:0]       loc;
    logic              last;
  } dir_rsp_t;

  logic clk;
  logic rst;
  cdlu_req_if req ();
  cdlu_rsp_if rsp ();

  content_directory_least_used dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  // directory shadow
  int          peer_cnt;
  logic [79:0] peer_tab [NPEER];
  int          fill [NPEER];
  logic [79:0] ent_key [NENT];
  logic [63:0] ent_loc [NENT];
  logic [15:0] ent_hits [NENT];

  dir_rsp_t    pending_rsp [$];
  logic [79:0] peer_pool [10];
  logic [79:0] item_pool [8];
  int          errors;
  int          hold_req;
  bit          calm;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void push_rsp(cdlu_pkg::status_t st, logic [79:0] pk,
                                   logic [79:0] ik, logic [63:0] loc, logic last);
    dir_rsp_t r;
    r.st = st;
    r.pkey = pk;
    r.ikey = ik;
    r.loc = loc;
    r.last = last;
    pending_rsp.push_back(r);
  endfunction

  function automatic int lookup_peer(logic [79:0] pk);
    for (int p = 0; p < peer_cnt; p++)
      if (peer_tab[p] == pk) return p;
    return -1;
  endfunction

  function automatic int slot_index(int p, logic [79:0] ik);
    for (int s = 0; s < fill[p]; s++)
      if (ent_key[p*NSLOT+s] == ik) return s;
    return -1;
  endfunction

  // work out the responses of one accepted request and update the shadow
  function automatic void directory_update(dir_req_t r);
    int p;
    int s;
    int best;
    int e;
    p = -1;
    best = -1;
    case (r.act)
      cdlu_pkg::ACT_REG: begin
        p = lookup_peer(r.pkey);
        if (p < 0) begin
          if (peer_cnt >= NPEER) begin
            push_rsp(cdlu_pkg::ST_PFULL, '0, '0, '0, 1'b1);
            return;
          end
          p = peer_cnt;
          peer_tab[p] = r.pkey;
          fill[p] = 0;
          peer_cnt++;
        end else if (slot_index(p, r.ikey) >= 0) begin
          push_rsp(cdlu_pkg::ST_DUP, '0, '0, '0, 1'b1);
          return;
        end else if (fill[p] >= NSLOT) begin
          push_rsp(cdlu_pkg::ST_SFULL, '0, '0, '0, 1'b1);
          return;
        end
        e = p * NSLOT + fill[p];
        ent_key[e] = r.ikey;
        ent_loc[e] = r.loc;
        ent_hits[e] = '0;
        fill[p]++;
        push_rsp(cdlu_pkg::ST_ACK, '0, '0, '0, 1'b1);
      end
      cdlu_pkg::ACT_SEARCH: begin
        for (int q = 0; q < peer_cnt; q++)
          for (int t = 0; t < fill[q]; t++) begin
            e = q * NSLOT + t;
            if (ent_key[e] == r.ikey && (best < 0 || ent_hits[e] < ent_hits[best]))
              best = e;
          end
        if (best < 0) begin
          push_rsp(cdlu_pkg::ST_NOCONT, '0, '0, '0, 1'b1);
        end else begin
          push_rsp(cdlu_pkg::ST_FOUND, peer_tab[best/NSLOT], ent_key[best], ent_loc[best],
                   1'b1);
          if (ent_hits[best] != cdlu_pkg::CNT_MAX) ent_hits[best]++;
        end
      end
      cdlu_pkg::ACT_DEREG, cdlu_pkg::ACT_DEREG_ALL: begin
        p = lookup_peer(r.pkey);
        if (p < 0) begin
          push_rsp(cdlu_pkg::ST_NOPEER, '0, '0, '0, 1'b1);
          return;
        end
        if (r.act == cdlu_pkg::ACT_DEREG_ALL) begin
          fill[p] = 0;
        end else begin
          s = slot_index(p, r.ikey);
          if (s < 0) begin
            push_rsp(cdlu_pkg::ST_NOCONT, '0, '0, '0, 1'b1);
            return;
          end
          // later entries move down whole
          for (int t = s; t + 1 < fill[p]; t++) begin
            ent_key[p*NSLOT+t] = ent_key[p*NSLOT+t+1];
            ent_loc[p*NSLOT+t] = ent_loc[p*NSLOT+t+1];
            ent_hits[p*NSLOT+t] = ent_hits[p*NSLOT+t+1];
          end
          fill[p]--;
        end
        push_rsp(cdlu_pkg::ST_ACK, '0, '0, '0, 1'b1);
      end
      cdlu_pkg::ACT_LIST: begin
        for (int q = 0; q < peer_cnt; q++)
          for (int t = 0; t < fill[q]; t++)
            push_rsp(cdlu_pkg::ST_ITEM, '0, ent_key[q*NSLOT+t], '0, 1'b0);
        push_rsp(cdlu_pkg::ST_END, '0, '0, '0, 1'b1);
      end
      default: ;
    endcase
  endfunction

  // send one request beat, with a random gap before it
  task automatic send_req(logic [2:0] act, logic [79:0] pk, logic [79:0] ik);
    int gap;
    int r;
    dir_req_t d;
    r = $urandom_range(0, 99);
    if (calm || r < 60) gap = 0;
    else if (r < 95) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    d.act = act;
    d.pkey = pk;
    d.ikey = ik;
    d.loc = {$urandom, $urandom};
    req.valid <= 1'b1;
    req.action <= d.act;
    req.peer_key_hi <= d.pkey[79:64];
    req.peer_key_lo <= d.pkey[63:0];
    req.item_key_hi <= d.ikey[79:64];
    req.item_key_lo <= d.ikey[63:0];
    req.locator_in <= d.loc;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    directory_update(d);
  endtask

  // response side readiness, with short stalls and a long hold-off on demand
  initial begin
    int hold_cnt;
    int r;
    hold_cnt = 0;
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        hold_cnt = hold_req;
        hold_req = 0;
      end
      r = $urandom_range(0, 99);
      if (hold_cnt > 0) begin
        hold_cnt--;
        rsp.ready <= 1'b0;
      end else if (calm || r < 70) begin
        rsp.ready <= 1'b1;
      end else if (r < 97) begin
        rsp.ready <= 1'b0;
      end else begin
        hold_cnt = $urandom_range(20, 60);
        rsp.ready <= 1'b0;
      end
    end
  end

  // check each response beat against the oldest expectation
  always @(posedge clk) begin
    dir_rsp_t got;
    dir_rsp_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      got.st = cdlu_pkg::status_t'(rsp.status);
      got.pkey = {rsp.peer_out_hi, rsp.peer_out_lo};
      got.ikey = {rsp.item_out_hi, rsp.item_out_lo};
      got.loc = rsp.locator_out;
      got.last = rsp.last;
      if (pending_rsp.size() == 0) begin
        $display("%0t beat: expected none got status %0d", $time, got.st);
        errors++;
      end else begin
        want = pending_rsp.pop_front();
        if (got.st !== want.st) begin
          $display("%0t status: expected %0d got %0d", $time, want.st, got.st);
          errors++;
        end
        if (got.pkey !== want.pkey) begin
          $display("%0t peer: expected %h got %h", $time, want.pkey, got.pkey);
          errors++;
        end
        if (got.ikey !== want.ikey) begin
          $display("%0t item: expected %h got %h", $time, want.ikey, got.ikey);
          errors++;
        end
        if (got.loc !== want.loc) begin
          $display("%0t locator: expected %h got %h", $time, want.loc, got.loc);
          errors++;
        end
        if (got.last !== want.last) begin
          $display("%0t last: expected %b got %b", $time, want.last, got.last);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no beat on either side
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle = 0;
      else idle++;
      if (idle >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic test_list_empty();
    send_req(cdlu_pkg::ACT_LIST, peer_pool[0], item_pool[0]);
  endtask

  task automatic test_register();
    send_req(cdlu_pkg::ACT_REG, peer_pool[0], item_pool[0]);
    send_req(cdlu_pkg::ACT_REG, peer_pool[0], item_pool[0]);
    for (int i = 1; i < 4; i++) send_req(cdlu_pkg::ACT_REG, peer_pool[0], item_pool[i]);
    send_req(cdlu_pkg::ACT_REG, peer_pool[0], item_pool[4]);
    send_req(cdlu_pkg::ACT_REG, peer_pool[1], item_pool[0]);
    for (int i = 2; i < 8; i++)
      send_req(cdlu_pkg::ACT_REG, peer_pool[i], item_pool[i % 8]);
    send_req(cdlu_pkg::ACT_REG, peer_pool[8], item_pool[1]);
  endtask

  task automatic test_search();
    // tie goes to the first peer, then the less used copy wins
    send_req(cdlu_pkg::ACT_SEARCH, peer_pool[3], item_pool[0]);
    send_req(cdlu_pkg::ACT_SEARCH, peer_pool[3], item_pool[0]);
    send_req(cdlu_pkg::ACT_SEARCH, peer_pool[3], item_pool[5]);
  endtask

  task automatic test_deregister();
    send_req(cdlu_pkg::ACT_DEREG, peer_pool[9], item_pool[0]);
    send_req(cdlu_pkg::ACT_DEREG, peer_pool[0], item_pool[5]);
    send_req(cdlu_pkg::ACT_DEREG, peer_pool[0], item_pool[1]);
    send_req(cdlu_pkg::ACT_DEREG_ALL, peer_pool[1], item_pool[0]);
    send_req(cdlu_pkg::ACT_LIST, peer_pool[0], item_pool[0]);
  endtask

  task automatic test_unused_actions();
    send_req(3'd5, peer_pool[0], item_pool[0]);
    send_req(3'd7, peer_pool[2], item_pool[2]);
  endtask

  task automatic test_pressure();
    hold_req = PRESSURE_CYCLES;
    for (int i = 0; i < 6; i++)
      send_req(cdlu_pkg::ACT_SEARCH, peer_pool[0], item_pool[i]);
    send_req(cdlu_pkg::ACT_LIST, peer_pool[0], item_pool[0]);
  endtask

  task automatic test_random(int n);
    int r;
    logic [2:0] act;
    logic [79:0] ik;
    for (int i = 0; i < n; i++) begin
      calm = (i % 100) >= 80;
      r = $urandom_range(0, 99);
      if (r < 38) act = cdlu_pkg::ACT_REG;
      else if (r < 63) act = cdlu_pkg::ACT_SEARCH;
      else if (r < 80) act = cdlu_pkg::ACT_DEREG;
      else if (r < 87) act = cdlu_pkg::ACT_DEREG_ALL;
      else if (r < 95) act = cdlu_pkg::ACT_LIST;
      else act = 3'($urandom_range(5, 7));
      ik = ($urandom_range(0, 9) == 0) ? 80'({$urandom, $urandom, $urandom})
                                      : item_pool[$urandom_range(0, 7)];
      send_req(act, peer_pool[$urandom_range(0, 9)], ik);
    end
    calm = 1'b0;
  endtask

  initial begin
    errors = 0;
    hold_req = 0;
    calm = 1'b0;
    peer_cnt = 0;
    for (int p = 0; p < NPEER; p++) fill[p] = 0;
    peer_pool[0] = '1;
    peer_pool[1] = '0;
    item_pool[0] = '1;
    item_pool[1] = '0;
    for (int i = 2; i < 10; i++) peer_pool[i] = 80'({$urandom, $urandom, $urandom});
    for (int i = 2; i < 8; i++) item_pool[i] = 80'({$urandom, $urandom, $urandom});
    rst = 1'b1;
    req.valid = 1'b0;
    req.action = '0;
    req.peer_key_hi = '0;
    req.peer_key_lo = '0;
    req.item_key_hi = '0;
    req.item_key_lo = '0;
    req.locator_in = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_list_empty();
    test_register();
    test_search();
    test_deregister();
    test_unused_actions();
    test_pressure();
    test_random(390);

    req.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
